// ----- rtl/core/dei_pkg.sv -----
// Shared constants, breakpoint tables, derived widths and types for the depth efficiency block.
package dei_pkg;

    localparam int TABLE_POINTS  = 48;
    localparam int SEGMENTS      = TABLE_POINTS - 1;
    localparam int FRACTION_BITS = 16;
    localparam int DEPTH_W       = 16;
    localparam int EFF_W         = FRACTION_BITS + 1;

    // Breakpoint efficiencies are held in units of 1e-5.
    localparam longint EFF_SCALE = 100000;

    // Breakpoint depths in 0.1 um steps, strictly falling.
    localparam int DEPTH_KNOTS [TABLE_POINTS] = '{
        20000, 19300, 18500, 17700, 17000, 16400, 15700, 15100, 14400,
        13900, 13300, 12800, 12300, 11800, 11500, 11100, 10800, 10500,
        10200, 10000,  9800,  9600,  9400,  9200,  9100,  8900,  8800,
         8600,  8500,  8300,  8100,  8000,  7800,  7700,  7500,  7400,
         7200,  7100,  6900,  6800,  6600,  6500,  6300,  6100,  5900,
         5700,  5600,     0
    };

    // Efficiencies at the breakpoints, rising toward 1.0.
    localparam int EFF_KNOTS [TABLE_POINTS] = '{
        77122, 77619, 78117, 78614, 79111, 79609, 80106, 80603, 81101,
        81598, 82095, 82593, 83090, 83587, 84085, 84582, 85080, 85577,
        86074, 86572, 87069, 87566, 88064, 88561, 89058, 89556, 90053,
        90550, 91048, 91545, 92042, 92540, 93037, 93534, 94032, 94529,
        95027, 95524, 96021, 96519, 97016, 97513, 98011, 98508, 99005,
        99503, 100000, 100000
    };

    function automatic int seg_den(input int idx);
        return DEPTH_KNOTS[idx] - DEPTH_KNOTS[idx + 1];
    endfunction

    function automatic int max_den();
        int m;
        m = 0;
        for (int i = 0; i < SEGMENTS; i++) begin
            if (seg_den(i) > m) begin
                m = seg_den(i);
            end
        end
        return m;
    endfunction

    function automatic int min_den();
        int m;
        m = seg_den(0);
        for (int i = 0; i < SEGMENTS; i++) begin
            if (seg_den(i) < m) begin
                m = seg_den(i);
            end
        end
        return m;
    endfunction

    function automatic int max_rise();
        int m;
        m = 0;
        for (int i = 0; i < SEGMENTS; i++) begin
            if (EFF_KNOTS[i + 1] - EFF_KNOTS[i] > m) begin
                m = EFF_KNOTS[i + 1] - EFF_KNOTS[i];
            end
        end
        return m;
    endfunction

    localparam int SEG_W    = $clog2(SEGMENTS);
    localparam int KNOT_W   = $clog2(DEPTH_KNOTS[0] + 1);
    localparam int CEFF_W   = $clog2(EFF_SCALE + 1);
    localparam int DEN_MAX  = max_den();
    localparam int DEN_MIN  = min_den();
    localparam int RISE_MAX = max_rise();
    localparam int DEN_W    = $clog2(DEN_MAX + 1);
    localparam int RISE_W   = $clog2(RISE_MAX + 1);

    // Segment numerator T, doubled divisor E = 2 * 1e5 * den.
    localparam longint T_MAX = EFF_SCALE * DEN_MAX;
    localparam longint E_MAX = 2 * EFF_SCALE * DEN_MAX;
    localparam longint E_MIN = 2 * EFF_SCALE * DEN_MIN;
    localparam int     T_W   = $clog2(T_MAX + 1);
    localparam int     E_W   = $clog2(E_MAX + 1);

    // Dividend X = T * 2^(F+1) + E/2; quotient X / E is the rounded result.
    localparam longint X_MAX = (T_MAX << (FRACTION_BITS + 1)) + E_MAX;
    localparam int     X_W   = $clog2(X_MAX + 1);
    localparam int     R_W   = $clog2(((longint'(1) << X_W) / E_MIN) + 1);
    localparam int     LO_W  = (X_W + 1) / 2;
    localparam int     HI_W  = X_W - LO_W;
    localparam int     SUM_W = X_W + R_W;
    localparam int     Q_W   = EFF_W;

    localparam logic [EFF_W-1:0] CLAMP_EFF = EFF_W'(
        ((longint'(EFF_KNOTS[0]) << FRACTION_BITS) + EFF_SCALE / 2) / EFF_SCALE);
    localparam logic [EFF_W-1:0] EFF_ONE = EFF_W'(longint'(1) << FRACTION_BITS);

    typedef struct packed {
        logic           clamped;
        logic [T_W-1:0] t;
        logic [E_W-1:0] e;
        logic [R_W-1:0] r;
    } seg_term_t;

endpackage

// ----- rtl/core/dei_seg_lookup.sv -----
// Segment search and table fetch: depth to numerator, divisor and reciprocal (3 stages).
module dei_seg_lookup (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dei_pkg::DEPTH_W-1:0]   in_depth,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dei_pkg::seg_term_t            out_term
);

    localparam int STAGES = 3;
    localparam int BASE_W = dei_pkg::CEFF_W + dei_pkg::DEN_W;
    localparam int SLOPE_W = dei_pkg::DEN_W + dei_pkg::RISE_W;
    localparam int ACC_W = ((BASE_W > SLOPE_W) ? BASE_W : SLOPE_W) + 1;

    // Per-segment constant tables
    logic [dei_pkg::KNOT_W-1:0] knot_tab [dei_pkg::SEGMENTS];
    logic [dei_pkg::CEFF_W-1:0] ceff_tab [dei_pkg::SEGMENTS];
    logic [dei_pkg::DEN_W-1:0]  den_tab  [dei_pkg::SEGMENTS];
    logic [dei_pkg::RISE_W-1:0] rise_tab [dei_pkg::SEGMENTS];
    logic [dei_pkg::E_W-1:0]    e_tab    [dei_pkg::SEGMENTS];
    logic [dei_pkg::R_W-1:0]    r_tab    [dei_pkg::SEGMENTS];

    for (genvar g = 0; g < dei_pkg::SEGMENTS; g++) begin : g_tab
        localparam longint DenG = longint'(dei_pkg::DEPTH_KNOTS[g] - dei_pkg::DEPTH_KNOTS[g + 1]);
        localparam longint EG   = 2 * dei_pkg::EFF_SCALE * DenG;
        localparam longint RecG = (longint'(1) << dei_pkg::X_W) / EG;
        assign knot_tab[g] = dei_pkg::KNOT_W'(dei_pkg::DEPTH_KNOTS[g]);
        assign ceff_tab[g] = dei_pkg::CEFF_W'(dei_pkg::EFF_KNOTS[g]);
        assign den_tab[g]  = dei_pkg::DEN_W'(DenG);
        assign rise_tab[g] = dei_pkg::RISE_W'(dei_pkg::EFF_KNOTS[g + 1] - dei_pkg::EFF_KNOTS[g]);
        assign e_tab[g]    = dei_pkg::E_W'(EG);
        assign r_tab[g]    = dei_pkg::R_W'(RecG);
    end

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] rdy;
    logic [STAGES-1:0] feed;

    logic [dei_pkg::DEPTH_W-1:0] depth1_reg;
    logic [dei_pkg::SEG_W-1:0]   seg2_reg;
    logic                        clamped2_reg;
    logic [dei_pkg::KNOT_W-1:0]  depth2_reg;
    dei_pkg::seg_term_t          term3_reg;

    logic [dei_pkg::SEG_W-1:0]   seg_next;
    logic                        clamped_next;
    logic [dei_pkg::DEN_W-1:0]   run;
    logic [BASE_W-1:0]           base_prod;
    logic [SLOPE_W-1:0]          slope_prod;
    logic [ACC_W-1:0]            acc;
    dei_pkg::seg_term_t          term_next;

    // Stage enables: a stage loads when empty or when its successor loads.
    always_comb begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k + 1];
        end
        feed = {valid_reg[STAGES-2:0], in_valid};
        valid_next = valid_reg;
        for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
                valid_next[k] = feed[k];
            end
        end
    end

    // Last breakpoint strictly above the depth; none means clamp.
    always_comb begin
        seg_next = '0;
        clamped_next = 1'b1;
        for (int i = 0; i < dei_pkg::SEGMENTS; i++) begin
            if (depth1_reg < dei_pkg::DEPTH_W'(dei_pkg::DEPTH_KNOTS[i])) begin
                seg_next = dei_pkg::SEG_W'(i);
                clamped_next = 1'b0;
            end
        end
    end

    // T = cL * den + (zL - depth) * rise
    always_comb begin
        run        = dei_pkg::DEN_W'(knot_tab[seg2_reg] - depth2_reg);
        base_prod  = BASE_W'(ceff_tab[seg2_reg]) * BASE_W'(den_tab[seg2_reg]);
        slope_prod = SLOPE_W'(run) * SLOPE_W'(rise_tab[seg2_reg]);
        acc        = ACC_W'(base_prod) + ACC_W'(slope_prod);
        term_next.clamped = clamped2_reg;
        term_next.t = clamped2_reg ? '0 : dei_pkg::T_W'(acc);
        term_next.e = e_tab[seg2_reg];
        term_next.r = r_tab[seg2_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            depth1_reg <= in_depth;
        end
        if (rdy[1]) begin
            seg2_reg     <= seg_next;
            clamped2_reg <= clamped_next;
            depth2_reg   <= depth1_reg[dei_pkg::KNOT_W-1:0];
        end
        if (rdy[2]) begin
            term3_reg <= term_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_term  = term3_reg;

endmodule

// ----- rtl/core/dei_recip_div.sv -----
// Rounded quotient X / E by table reciprocal, one correction step, output register (5 stages).
module dei_recip_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dei_pkg::seg_term_t            in_term,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dei_pkg::EFF_W-1:0]     out_efficiency,
    output logic                          out_clamped
);

    localparam int STAGES = 5;
    localparam int PLO_W  = dei_pkg::LO_W + dei_pkg::R_W;
    localparam int PHI_W  = dei_pkg::HI_W + dei_pkg::R_W;
    localparam int PROD_W = dei_pkg::Q_W + dei_pkg::E_W;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] rdy;
    logic [STAGES-1:0] feed;

    // stage 1: dividend
    logic [dei_pkg::X_W-1:0] x1_reg;
    logic [dei_pkg::E_W-1:0] e1_reg;
    logic [dei_pkg::R_W-1:0] r1_reg;
    logic                    c1_reg;
    // stage 2: partial products of X * R
    logic [dei_pkg::X_W-1:0] x2_reg;
    logic [dei_pkg::E_W-1:0] e2_reg;
    logic                    c2_reg;
    logic [PLO_W-1:0]        plo2_reg;
    logic [PHI_W-1:0]        phi2_reg;
    // stage 3: quotient estimate
    logic [dei_pkg::X_W-1:0] x3_reg;
    logic [dei_pkg::E_W-1:0] e3_reg;
    logic                    c3_reg;
    logic [dei_pkg::Q_W-1:0] q3_reg;
    // stage 4: back-multiplied estimate
    logic [dei_pkg::X_W-1:0] x4_reg;
    logic [dei_pkg::E_W-1:0] e4_reg;
    logic                    c4_reg;
    logic [dei_pkg::Q_W-1:0] q4_reg;
    logic [dei_pkg::X_W-1:0] prod4_reg;
    // stage 5: output
    logic [dei_pkg::EFF_W-1:0] eff5_reg;
    logic                      c5_reg;

    logic [dei_pkg::X_W-1:0]   x_next;
    logic [PLO_W-1:0]          plo_next;
    logic [PHI_W-1:0]          phi_next;
    logic [dei_pkg::SUM_W-1:0] sum_next;
    logic [PROD_W-1:0]         prod_full;
    logic [dei_pkg::X_W-1:0]   rem_next;
    logic                      bump;
    logic [dei_pkg::EFF_W-1:0] eff_next;

    always_comb begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k + 1];
        end
        feed = {valid_reg[STAGES-2:0], in_valid};
        valid_next = valid_reg;
        for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
                valid_next[k] = feed[k];
            end
        end
    end

    always_comb begin
        // half the doubled divisor gives round half up
        x_next    = (dei_pkg::X_W'(in_term.t) << (dei_pkg::FRACTION_BITS + 1))
                  + dei_pkg::X_W'(in_term.e >> 1);
        plo_next  = PLO_W'(x1_reg[dei_pkg::LO_W-1:0]) * PLO_W'(r1_reg);
        phi_next  = PHI_W'(x1_reg[dei_pkg::X_W-1:dei_pkg::LO_W]) * PHI_W'(r1_reg);
        sum_next  = (dei_pkg::SUM_W'(phi2_reg) << dei_pkg::LO_W) + dei_pkg::SUM_W'(plo2_reg);
        prod_full = PROD_W'(q3_reg) * PROD_W'(e3_reg);
        // estimate is exact or one low; the remainder tells which
        rem_next  = x4_reg - prod4_reg;
        bump      = rem_next >= dei_pkg::X_W'(e4_reg);
        eff_next  = c4_reg ? dei_pkg::CLAMP_EFF : (q4_reg + dei_pkg::EFF_W'(bump));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            x1_reg <= x_next;
            e1_reg <= in_term.e;
            r1_reg <= in_term.r;
            c1_reg <= in_term.clamped;
        end
        if (rdy[1]) begin
            x2_reg   <= x1_reg;
            e2_reg   <= e1_reg;
            c2_reg   <= c1_reg;
            plo2_reg <= plo_next;
            phi2_reg <= phi_next;
        end
        if (rdy[2]) begin
            x3_reg <= x2_reg;
            e3_reg <= e2_reg;
            c3_reg <= c2_reg;
            q3_reg <= sum_next[dei_pkg::X_W +: dei_pkg::Q_W];
        end
        if (rdy[3]) begin
            x4_reg    <= x3_reg;
            e4_reg    <= e3_reg;
            c4_reg    <= c3_reg;
            q4_reg    <= q3_reg;
            prod4_reg <= prod_full[dei_pkg::X_W-1:0];
        end
        if (rdy[4]) begin
            eff5_reg <= eff_next;
            c5_reg   <= c4_reg;
        end
    end

    assign in_ready       = rdy[0];
    assign out_valid      = valid_reg[STAGES-1];
    assign out_efficiency = eff5_reg;
    assign out_clamped    = c5_reg;

endmodule

// ----- rtl/core/depth_efficiency_interpolator.sv -----
// Top level of the depth efficiency interpolator: segment lookup feeding the reciprocal divider.
//
// Usage:
//   Input channel (s_valid/s_ready/s_depth): one beat carries one interaction depth in
//   0.1 um steps. Result channel (m_valid/m_ready/m_efficiency/m_clamped): one beat per
//   input beat, in order, carrying the linearly interpolated collection efficiency with
//   16 fraction bits (65536 = 1.0). Depths of 2 mm (20000) and more return the first table
//   entry with m_clamped set.
//   Pipeline: 3 lookup stages (segment search, table fetch and segment numerator) and
//   5 divider stages (dividend, split reciprocal product, quotient estimate, back product,
//   correction into the output register). Each depth is registered through all of these stages in
//   order. One beat per cycle is sustained while m_ready stays high; the rate is
//   set by the per-stage handshake, every stage holds one beat.
//   Stalls: each stage loads when empty or when its successor moves, so with m_ready low
//   the pipeline keeps taking beats until all 8 stages are full; nothing is dropped or
//   repeated. s_ready drops only when every stage holds a beat.
//   Reset (aresetn low at a clock edge) empties the pipeline: m_valid goes low and s_ready
//   goes high. There is no configuration and no state between beats.
module depth_efficiency_interpolator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dei_pkg::DEPTH_W-1:0]   s_depth,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dei_pkg::EFF_W-1:0]     m_efficiency,
    output logic                          m_clamped
);

    // lookup -> divider
    logic               term_valid;
    logic               term_ready;
    dei_pkg::seg_term_t term;

    dei_seg_lookup u_lookup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_depth  (s_depth),
        .out_valid (term_valid),
        .out_ready (term_ready),
        .out_term  (term)
    );

    dei_recip_div u_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (term_valid),
        .in_ready       (term_ready),
        .in_term        (term),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_efficiency (m_efficiency),
        .out_clamped    (m_clamped)
    );

endmodule

// ----- rtl/core/dei_checker.sv -----
// Port-level checker for the depth efficiency interpolator, bound to the top level.
module dei_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [dei_pkg::DEPTH_W-1:0]   s_depth,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [dei_pkg::EFF_W-1:0]     m_efficiency,
    input logic                          m_clamped
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_efficiency) && $stable(m_clamped))
        else $error("result beat changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    a_clamp_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clamped |-> m_efficiency == dei_pkg::CLAMP_EFF)
        else $error("clamped beat carries wrong efficiency");

    // interpolated values stay between the first entry and 1.0
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_clamped |->
            m_efficiency >= dei_pkg::CLAMP_EFF && m_efficiency <= dei_pkg::EFF_ONE)
        else $error("efficiency out of table range");

endmodule

bind depth_efficiency_interpolator dei_checker u_dei_checker (.*);

// ----- bench/depth_efficiency_interpolator_tb.sv -----
// Self-checking testbench for the depth efficiency interpolator: directed and random depths.
module depth_efficiency_interpolator_tb;

    localparam int DEPTH_W       = dei_pkg::DEPTH_W;
    localparam int EFF_W         = dei_pkg::EFF_W;
    localparam int FRACTION_BITS = dei_pkg::FRACTION_BITS;
    localparam int TABLE_POINTS  = dei_pkg::TABLE_POINTS;

    // Cycles without any accepted beat before the run is declared hung. The receiver stalls
    // and sender gaps drawn below are far shorter, so this is generous.
    localparam int HANG_LIMIT = 2000;
    // Cycles to keep watching after the last result, to catch extra beats.
    localparam int DRAIN_CYCLES = 24;

    // Breakpoint depths (0.1 um steps) and efficiencies (1e-5 units), kept separately from
    // the RTL tables so that a bad ROM entry shows up as a mismatch.
    localparam int KNOT_DEPTH [TABLE_POINTS] = '{
        20000, 19300, 18500, 17700, 17000, 16400, 15700, 15100, 14400,
        13900, 13300, 12800, 12300, 11800, 11500, 11100, 10800, 10500,
        10200, 10000,  9800,  9600,  9400,  9200,  9100,  8900,  8800,
         8600,  8500,  8300,  8100,  8000,  7800,  7700,  7500,  7400,
         7200,  7100,  6900,  6800,  6600,  6500,  6300,  6100,  5900,
         5700,  5600,     0
    };
    localparam int KNOT_EFF [TABLE_POINTS] = '{
        77122, 77619, 78117, 78614, 79111, 79609, 80106, 80603, 81101,
        81598, 82095, 82593, 83090, 83587, 84085, 84582, 85080, 85577,
        86074, 86572, 87069, 87566, 88064, 88561, 89058, 89556, 90053,
        90550, 91048, 91545, 92042, 92540, 93037, 93534, 94032, 94529,
        95027, 95524, 96021, 96519, 97016, 97513, 98011, 98508, 99005,
        99503, 100000, 100000
    };

    // One result beat as it should come out, with the depth that caused it for reports.
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [EFF_W-1:0]   efficiency;
        logic               clamped;
    } eff_beat_t;

    // Receiver behavior: always ready, randomly choppy, or long alternating stall runs.
    typedef enum {RX_OPEN, RX_CHOPPY, RX_LONG} rx_mode_t;

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [DEPTH_W-1:0] s_depth      = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic [EFF_W-1:0]   m_efficiency;
    logic               m_clamped;

    eff_beat_t expected_beats [$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    rx_mode_t  rx_mode        = RX_OPEN;
    int        rx_left        = 0;
    bit        tx_steady      = 1'b1;
    int        burst_left     = 0;

    depth_efficiency_interpolator dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_depth      (s_depth),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_efficiency (m_efficiency),
        .m_clamped    (m_clamped)
    );

    always #5 aclk = ~aclk;

    // Expected efficiency for one depth. The segment starts at the last knot that lies
    // strictly above the depth; the last knot is 0, so the segment never runs off the end.
    // The segment value T = cL*den + (zL - depth)*(cL1 - cL) is in 1e-5/den units and is
    // rounded to FRACTION_BITS fraction bits, halves up. Depths at or past 2 mm clamp to
    // the first knot's efficiency.
    function automatic eff_beat_t predict_efficiency(input logic [DEPTH_W-1:0] depth);
        eff_beat_t beat;
        int        seg;
        bit        hit;
        longint    den;
        longint    num;
        longint    divisor;
        longint    quo;
        seg = 0;
        hit = 1'b0;
        for (int i = 0; i < TABLE_POINTS; i++) begin
            if (int'(depth) < KNOT_DEPTH[i]) begin
                seg = i;
                hit = 1'b1;
            end
        end
        if (hit) begin
            den = KNOT_DEPTH[seg] - KNOT_DEPTH[seg + 1];
            num = longint'(KNOT_EFF[seg]) * den
                + longint'(KNOT_DEPTH[seg] - int'(depth)) * (KNOT_EFF[seg + 1] - KNOT_EFF[seg]);
        end else begin
            den = 1;
            num = KNOT_EFF[0];
        end
        divisor = 100000 * den;
        quo = ((num << FRACTION_BITS) + divisor / 2) / divisor;
        beat.depth      = depth;
        beat.efficiency = quo[EFF_W-1:0];
        beat.clamped    = !hit;
        return beat;
    endfunction

    // Sender pacing: bursts of random length separated by random gaps, or none at all
    // when tx_steady is set. Called right after a beat is taken, so a gap lowers valid
    // in the same step that the last beat went through.
    task automatic tx_pause();
        int gap_len;
        if (!tx_steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 24);
                gap_len    = $urandom_range(1, 12);
                s_valid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
    endtask

    // Offer one depth, hold it until the block takes it, log the expected result.
    task automatic send_depth(input logic [DEPTH_W-1:0] depth);
        s_valid <= 1'b1;
        s_depth <= depth;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        expected_beats.push_back(predict_efficiency(depth));
        tx_pause();
    endtask

    // Receiver: ready pattern chosen per test. In RX_LONG, ready and stall runs alternate
    // with lengths drawn fresh each time, and stalls long enough that the pipe fills and
    // s_ready is forced low.
    always @(posedge aclk) begin
        case (rx_mode)
            RX_OPEN: begin
                m_ready <= 1'b1;
            end
            RX_CHOPPY: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (rx_left == 0) begin
                    m_ready <= !m_ready;
                    rx_left <= m_ready ? $urandom_range(1, 40) : $urandom_range(1, 12);
                end else begin
                    rx_left <= rx_left - 1;
                end
            end
        endcase
    end

    // Result checker: every beat taken on the result side must match the oldest
    // outstanding expectation, field by field.
    always @(posedge aclk) begin
        eff_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: result beat with nothing expected: eff %0d clamped %0d",
                         $time, m_efficiency, m_clamped);
                mismatch_count++;
            end else begin
                want = expected_beats.pop_front();
                if (m_efficiency !== want.efficiency) begin
                    $display("%0t: depth %0d efficiency expected %0d actual %0d",
                             $time, want.depth, want.efficiency, m_efficiency);
                    mismatch_count++;
                end
                if (m_clamped !== want.clamped) begin
                    $display("%0t: depth %0d clamped expected %0d actual %0d",
                             $time, want.depth, want.clamped, m_clamped);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang detector: counts cycles with no beat accepted on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, HANG_LIMIT);
            $display("depth_efficiency_interpolator_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Table edges: zero, knot boundaries at both ends of the table, the clamp threshold
    // and beyond, and alternating bit patterns. Sender and receiver never idle here.
    task automatic test_table_edges();
        logic [DEPTH_W-1:0] edge_depths [$];
        edge_depths = {16'd0, 16'd1, 16'd2, 16'd5599, 16'd5600, 16'd5601, 16'd5699,
                       16'd5700, 16'd9150, 16'd10000, 16'd19299, 16'd19300, 16'd19301,
                       16'd19999, 16'd20000, 16'd20001, 16'd21845, 16'd32767, 16'd32768,
                       16'd43690, 16'd65534, 16'd65535};
        tx_steady = 1'b1;
        rx_mode   = RX_OPEN;
        foreach (edge_depths[i]) begin
            send_depth(edge_depths[i]);
        end
    endtask

    // Depths within a few steps of a random knot, where segment selection can go wrong.
    task automatic test_knot_neighborhood(input int count);
        int v;
        tx_steady = 1'b0;
        rx_mode   = RX_CHOPPY;
        repeat (count) begin
            v = KNOT_DEPTH[$urandom_range(0, TABLE_POINTS - 1)] + int'($urandom_range(0, 6)) - 3;
            if (v < 0) begin
                v = 0;
            end
            send_depth(DEPTH_W'(v));
        end
    endtask

    // Uniform depths inside the table, under long receiver stalls.
    task automatic test_in_range_depths(input int count);
        tx_steady = 1'b0;
        rx_mode   = RX_LONG;
        repeat (count) begin
            send_depth(DEPTH_W'($urandom_range(0, 19999)));
        end
    endtask

    // Full 16-bit range with the sender never pausing, so long stalls back up into s_ready.
    task automatic test_full_range_pressure(input int count);
        tx_steady = 1'b1;
        rx_mode   = RX_LONG;
        repeat (count) begin
            send_depth(DEPTH_W'($urandom_range(0, 65535)));
        end
    endtask

    // Back-to-back beats with an always-ready receiver: one result per cycle.
    task automatic test_streaming(input int count);
        tx_steady = 1'b1;
        rx_mode   = RX_OPEN;
        repeat (count) begin
            send_depth(DEPTH_W'($urandom_range(0, 22000)));
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_table_edges();
        test_knot_neighborhood(700);
        test_in_range_depths(650);
        test_full_range_pressure(450);
        test_streaming(200);
        s_valid <= 1'b0;

        // Let the pipe drain, then watch a little longer for stray beats.
        rx_mode = RX_CHOPPY;
        while (expected_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("depth_efficiency_interpolator_tb OK");
        end else begin
            $display("depth_efficiency_interpolator_tb NOT OK");
        end
        $finish;
    end

endmodule
